// File: sv/load_cell_calibrated_fir_defines.svh
// ----------------------------------------------------------------------------
// load_cell_calibrated_fir assertion macros
// shorthand for the clocked properties used by the port checker
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_CALIBRATED_FIR_DEFINES_SVH
`define LOAD_CELL_CALIBRATED_FIR_DEFINES_SVH

// condition now implies consequence on the next edge, ignored in reset
`define LCCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// state right after a reset edge
`define LCCF_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) else $error(msg);

`endif

// File: sv/lccf_pkg.sv
// ----------------------------------------------------------------------------
// lccf_pkg
// shared constants, types and helper functions of the calibrated load cell fir
// ----------------------------------------------------------------------------
package lccf_pkg;

    localparam int TAPS             = 11;
    localparam int HIST             = TAPS - 1;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int CAL_SHIFT        = 48 - WEIGHT_FRAC_BITS;

    localparam int SAMPLE_W   = 32;
    localparam int GAIN_W     = 40;
    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = 15;
    localparam int WEIGHT_W   = 40;
    localparam int NCOEF      = 6;
    localparam int COEF_IDX_W = $clog2(NCOEF);
    localparam int DIFF_W     = SAMPLE_W + 1;

    localparam int CHUNK_W     = 16;
    localparam int CAL_CHUNKS  = (GAIN_W + CHUNK_W - 1) / CHUNK_W;
    localparam int GAIN_EXT_W  = CAL_CHUNKS * CHUNK_W;
    localparam int CHUNK_CNT_W = $clog2(CAL_CHUNKS);
    localparam int TAP_CNT_W   = $clog2(TAPS);

    localparam int MUL_A_W = WEIGHT_W + 1;
    localparam int MUL_B_W = CHUNK_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = DIFF_W + GAIN_W + 1;

    localparam int REG_IDX_W = 3;
    localparam int CFG_W     = 40;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 2 * WEIGHT_W;

    localparam logic signed [SAMPLE_W-1:0] ZERO_OFFSET_RST = 32'sd39149384;
    localparam logic        [GAIN_W-1:0]   SCALE_GAIN_RST  = 40'd29011410000;
    localparam logic signed [COEF_W-1:0]   COEF_RST [NCOEF] =
        '{16'sd13061, 16'sd9033, 16'sd2108, -16'sd845, -16'sd443, 16'sd0};

    localparam logic signed [ACC_W-1:0] ACC_WMAX =
        {{(ACC_W-WEIGHT_W+1){1'b0}}, {(WEIGHT_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_WMIN = ~ACC_WMAX;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS =
        {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ZERO_OFFSET,
        REG_SCALE_GAIN,
        REG_COEF_CENTER,
        REG_COEF_OFF1,
        REG_COEF_OFF2,
        REG_COEF_OFF3,
        REG_COEF_OFF4,
        REG_COEF_OFF5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAL,
        ST_CAL_DRAIN,
        ST_WEIGHT,
        ST_FIR,
        ST_FIR_DRAIN,
        ST_ROUND
    } state_t;

    typedef struct packed {
        logic issue;
        logic shift;
        logic clear;
    } mac_ctl_t;

    typedef struct packed {
        logic fill;
        logic rotate;
        logic shift_in;
    } dline_ctl_t;

    function automatic logic signed [WEIGHT_W-1:0] sat_weight(
        input logic signed [ACC_W-1:0] v);
        logic signed [WEIGHT_W-1:0] r;
        if (v > ACC_WMAX) begin
            r = ACC_WMAX[WEIGHT_W-1:0];
        end else if (v < ACC_WMIN) begin
            r = ACC_WMIN[WEIGHT_W-1:0];
        end else begin
            r = v[WEIGHT_W-1:0];
        end
        return r;
    endfunction

    // coefficient register for a tap: distance from the center, rounded down
    function automatic logic [COEF_IDX_W-1:0] coef_idx(input logic [TAP_CNT_W-1:0] n);
        int d;
        d = 2 * int'(n) - (TAPS - 1);
        if (d < 0) begin
            d = -d;
        end
        d = d >>> 1;
        if (d > NCOEF - 1) begin
            d = NCOEF - 1;
        end
        return COEF_IDX_W'(d);
    endfunction

endpackage

// File: sv/lccf_mac.sv
// ----------------------------------------------------------------------------
// lccf_mac
// shared signed multiply-accumulate unit, product registered before the add
// ----------------------------------------------------------------------------
module lccf_mac
    import lccf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mac_ctl_t                 ctl,
    input  logic signed [MUL_A_W-1:0] mul_a,
    input  logic signed [MUL_B_W-1:0] mul_b,
    output logic signed [ACC_W-1:0]   acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_vld_reg;
    logic                     prod_shift_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_base;

    assign prod_next = mul_a * mul_b;

    always_comb begin
        acc_base = prod_shift_reg ? (acc_reg <<< CHUNK_W) : acc_reg;
        acc_next = acc_reg;
        if (ctl.clear) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_base + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctl.issue;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg       <= prod_next;
        prod_shift_reg <= ctl.shift;
        acc_reg        <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// File: sv/lccf_dline.sv
// ----------------------------------------------------------------------------
// lccf_dline
// weight delay line: fill, circular rotate for tap readout, shift in
// ----------------------------------------------------------------------------
module lccf_dline
    import lccf_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dline_ctl_t                 ctl,
    input  logic signed [WEIGHT_W-1:0] din,
    output logic signed [WEIGHT_W-1:0] tail
);

    logic signed [WEIGHT_W-1:0] dl_reg  [HIST];
    logic signed [WEIGHT_W-1:0] dl_next [HIST];

    always_comb begin
        dl_next = dl_reg;
        if (ctl.fill) begin
            for (int i = 0; i < HIST; i++) begin
                dl_next[i] = din;
            end
        end else if (ctl.rotate) begin
            dl_next[0] = dl_reg[HIST-1];
            for (int i = 1; i < HIST; i++) begin
                dl_next[i] = dl_reg[i-1];
            end
        end else if (ctl.shift_in) begin
            dl_next[0] = din;
            for (int i = 1; i < HIST; i++) begin
                dl_next[i] = dl_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST; i++) begin
                dl_reg[i] <= '0;
            end
        end else begin
            dl_reg <= dl_next;
        end
    end

    assign tail = dl_reg[HIST-1];

endmodule

// File: sv/load_cell_calibrated_fir.sv
// ----------------------------------------------------------------------------
// load_cell_calibrated_fir
// Takes one signed 32-bit load cell sample per word, forms the calibrated
// weight floor((sample - zero_offset) * scale_gain / 2^32) in signed Q.16,
// saturated to 40 bits, and runs it through an 11-tap symmetric FIR with
// Q1.15 coefficients (rounded half up, saturated to 40 bits). s_tuser[0] set
// starts a record: the delay line is filled with that word's weight first.
// All arithmetic goes through one shared 41x17 signed multiply-accumulate
// unit: 3 passes for the calibration product, 11 for the filter taps, so a
// new word is taken only once the last result is in the output register.
// s_tready is high only while idle; a finished result waits in the output
// register and does not block the next word until the next result is due.
// ----------------------------------------------------------------------------
module load_cell_calibrated_fir
    import lccf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // adc_sample
    input  logic [S_TUSER_W-1:0] s_tuser,   // first_sample
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // calibrated_weight, filtered_weight
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    state_t state_reg;
    state_t state_next;

    logic signed [SAMPLE_W-1:0] zero_offset_reg;
    logic        [GAIN_W-1:0]   scale_gain_reg;
    logic signed [COEF_W-1:0]   coef_reg [NCOEF];

    logic signed [DIFF_W-1:0]   diff_reg;
    logic                       first_reg;
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic [CHUNK_CNT_W-1:0]     chunk_cnt_reg;
    logic [CHUNK_CNT_W-1:0]     chunk_cnt_next;
    logic [TAP_CNT_W-1:0]       tap_cnt_reg;
    logic [TAP_CNT_W-1:0]       tap_cnt_next;

    logic signed [WEIGHT_W-1:0] out_cal_reg;
    logic signed [WEIGHT_W-1:0] out_filt_reg;
    logic                       m_tvalid_reg;

    mac_ctl_t   mac_ctl;
    dline_ctl_t dl_ctl;
    logic       load_weight;
    logic       load_out;

    logic        [GAIN_EXT_W-1:0] gain_ext;
    logic        [CHUNK_W-1:0]    gain_chunk;
    logic signed [WEIGHT_W-1:0]   tap_val;
    logic signed [WEIGHT_W-1:0]   dl_tail;
    logic signed [WEIGHT_W-1:0]   dl_din;
    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [ACC_W-1:0]      acc;
    logic signed [WEIGHT_W-1:0]   cal_weight;
    logic signed [WEIGHT_W-1:0]   filt_weight;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_offset_reg <= ZERO_OFFSET_RST;
            scale_gain_reg  <= SCALE_GAIN_RST;
            coef_reg        <= COEF_RST;
        end else if (cfg_wr_en) begin
            case (reg_idx_t'(cfg_index))
                REG_ZERO_OFFSET: zero_offset_reg <= cfg_wdata[SAMPLE_W-1:0];
                REG_SCALE_GAIN:  scale_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_COEF_CENTER: coef_reg[0]     <= cfg_wdata[COEF_W-1:0];
                REG_COEF_OFF1:   coef_reg[1]     <= cfg_wdata[COEF_W-1:0];
                REG_COEF_OFF2:   coef_reg[2]     <= cfg_wdata[COEF_W-1:0];
                REG_COEF_OFF3:   coef_reg[3]     <= cfg_wdata[COEF_W-1:0];
                REG_COEF_OFF4:   coef_reg[4]     <= cfg_wdata[COEF_W-1:0];
                REG_COEF_OFF5:   coef_reg[5]     <= cfg_wdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // operand selection for the shared unit
    assign gain_ext   = {{(GAIN_EXT_W-GAIN_W){1'b0}}, scale_gain_reg};
    assign gain_chunk = gain_ext[GAIN_EXT_W-1-CHUNK_W*int'(chunk_cnt_reg) -: CHUNK_W];
    assign tap_val    = (tap_cnt_reg == '0) ? weight_reg : dl_tail;

    always_comb begin
        if (state_reg == ST_CAL) begin
            mul_a = MUL_A_W'(diff_reg);
            mul_b = signed'({1'b0, gain_chunk});
        end else begin
            mul_a = MUL_A_W'(tap_val);
            mul_b = MUL_B_W'(coef_reg[coef_idx(tap_cnt_reg)]);
        end
    end

    assign cal_weight  = sat_weight(acc >>> CAL_SHIFT);
    assign filt_weight = sat_weight((acc + ROUND_BIAS) >>> COEF_FRAC);
    assign dl_din      = (state_reg == ST_WEIGHT) ? cal_weight : weight_reg;

    lccf_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .acc     (acc)
    );

    lccf_dline u_dline (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (dl_ctl),
        .din     (dl_din),
        .tail    (dl_tail)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            chunk_cnt_reg <= '0;
            tap_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chunk_cnt_reg <= chunk_cnt_next;
            tap_cnt_reg   <= tap_cnt_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        chunk_cnt_next = chunk_cnt_reg;
        tap_cnt_next   = tap_cnt_reg;
        mac_ctl        = '0;
        dl_ctl         = '0;
        load_weight    = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mac_ctl.clear  = 1'b1;
                    chunk_cnt_next = '0;
                    state_next     = ST_CAL;
                end
            end
            ST_CAL: begin
                mac_ctl.issue = 1'b1;
                mac_ctl.shift = 1'b1;
                if (chunk_cnt_reg == CHUNK_CNT_W'(CAL_CHUNKS - 1)) begin
                    state_next = ST_CAL_DRAIN;
                end else begin
                    chunk_cnt_next = chunk_cnt_reg + CHUNK_CNT_W'(1);
                end
            end
            ST_CAL_DRAIN: begin
                state_next = ST_WEIGHT;
            end
            ST_WEIGHT: begin
                load_weight   = 1'b1;
                dl_ctl.fill   = first_reg;
                mac_ctl.clear = 1'b1;
                tap_cnt_next  = TAP_CNT_W'(TAPS - 1);
                state_next    = ST_FIR;
            end
            ST_FIR: begin
                mac_ctl.issue = 1'b1;
                if (tap_cnt_reg == '0) begin
                    state_next = ST_FIR_DRAIN;
                end else begin
                    dl_ctl.rotate = 1'b1;
                    tap_cnt_next  = tap_cnt_reg - TAP_CNT_W'(1);
                end
            end
            ST_FIR_DRAIN: begin
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out        = 1'b1;
                    dl_ctl.shift_in = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // word capture and result registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            diff_reg  <= DIFF_W'(signed'(s_tdata[SAMPLE_W-1:0])) - DIFF_W'(zero_offset_reg);
            first_reg <= s_tuser[0];
        end
        if (load_weight) begin
            weight_reg <= cal_weight;
        end
        if (load_out) begin
            out_cal_reg  <= weight_reg;
            out_filt_reg <= filt_weight;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_filt_reg, out_cal_reg};

endmodule

// File: sv/lccf_checker.sv
// ----------------------------------------------------------------------------
// lccf_checker
// port-level checks of the calibrated load cell fir, bound to the top level
// ----------------------------------------------------------------------------
`include "load_cell_calibrated_fir_defines.svh"

module lccf_checker
    import lccf_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `LCCF_ASSERT_NEXT(a_m_hold_valid, m_tvalid && !m_tready, m_tvalid, "stalled word dropped")
    `LCCF_ASSERT_NEXT(a_m_hold_data, m_tvalid && !m_tready, $stable(m_tdata), "stalled word changed")
    `LCCF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready while busy")
    `LCCF_ASSERT_NEXT(a_idle_take_empties, m_tvalid && m_tready && s_tready, !m_tvalid,
                      "result appeared without work")
    `LCCF_ASSERT_RST(a_reset_idle, !m_tvalid && s_tready, "not idle after reset")

endmodule

bind load_cell_calibrated_fir lccf_checker u_lccf_checker (.*);
